[design/skdb_pkg.sv]
// shared widths, types and register codes for the spectral kalman denoiser
package skdb_pkg;

  localparam int BINS_DEF    = 4096;
  localparam int BIN_W       = 12;
  localparam int CUR_W       = 24;
  localparam int VAR_W       = 32;
  localparam int RATIO_W     = 16;
  localparam int SUM_W       = VAR_W + 1;
  localparam int DEN_W       = VAR_W + 2;
  localparam int Q_W         = 17;
  localparam int G_W         = 16;
  localparam int NUM_W       = SUM_W + G_W + 1;
  localparam int D_W         = CUR_W + 1;
  localparam int SQ_W        = 2 * CUR_W + 1;
  localparam int THR_W       = VAR_W + RATIO_W;
  localparam int DIV_STAGES  = Q_W;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [VAR_W-1:0]   NOISE_RST = 32'd256;
  localparam logic [RATIO_W-1:0] RATIO_RST = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_MODE,
    REG_NOISE_LEVEL,
    REG_MOTION_RATIO
  } cfg_reg_t;

  // per-bin state word
  typedef struct packed {
    logic signed [CUR_W-1:0] prev_re;
    logic signed [CUR_W-1:0] prev_im;
    logic [VAR_W-1:0]        err_re;
    logic [VAR_W-1:0]        err_im;
    logic [VAR_W-1:0]        proc_re;
    logic [VAR_W-1:0]        proc_im;
  } ent_t;

  // operands that ride alongside the gain division
  typedef struct packed {
    logic signed [CUR_W-1:0] cur_re;
    logic signed [CUR_W-1:0] cur_im;
    logic signed [CUR_W-1:0] prev_re;
    logic signed [CUR_W-1:0] prev_im;
    logic [SUM_W-1:0]        sum_re;
    logic [SUM_W-1:0]        sum_im;
    logic [VAR_W-1:0]        noise;
    logic signed [D_W-1:0]   d_re;
    logic signed [D_W-1:0]   d_im;
    logic                    motion;
  } side_t;

endpackage

[design/spectral_kalman_denoise_bin.sv]
// stages: a, b, c, s1, s2, the 17-stage gain divider, p1, p2 and the output register
// throughput: one bin per cycle unless m_tready holds the output; a bin whose previous
//   update is still in flight waits until that update is written back
// reset: synchronous; afterwards a clearing pass zeroes every entry of the bin store,
//   during which no input is taken (configuration writes are)
module spectral_kalman_denoise_bin #(
  parameter int BINS = skdb_pkg::BINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [skdb_pkg::IN_TDATA_W-1:0]  s_tdata,   // bin_index, cur_re, cur_im, bin_noise
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [skdb_pkg::OUT_TDATA_W-1:0] m_tdata,   // out_re, out_im
  output logic                             m_tuser,   // motion_reset
  input  logic                             cfg_we,
  input  logic [skdb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [skdb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import skdb_pkg::*;

  localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int NH     = DIV_STAGES + 5;
  localparam int MW     = 34;
  localparam logic [24:0] RECIP =
    25'(((64'd1 << 24) + 64'(BINS) - 64'd1) / 64'(BINS));

  function automatic logic [VAR_W-1:0] sat32(input logic [34:0] v);
    return (v[34:VAR_W] != '0) ? {VAR_W{1'b1}} : v[VAR_W-1:0];
  endfunction

  function automatic logic signed [CUR_W-1:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[CUR_W-1:0];
    end
  endfunction

  function automatic logic [G_W-1:0] gain_of(input logic [Q_W-1:0] q,
                                             input logic [SUM_W-1:0] sum,
                                             input logic [VAR_W-1:0] noise);
    if (sum == '0 && noise == '0) begin
      return '0;
    end else if (q[Q_W-1]) begin
      return {G_W{1'b1}};
    end else begin
      return q[G_W-1:0];
    end
  endfunction

  // configuration
  logic               pattern_mode;
  logic [VAR_W-1:0]   noise_level;
  logic [RATIO_W-1:0] motion_ratio_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode    <= 1'b0;
      noise_level     <= NOISE_RST;
      motion_ratio_sq <= RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PATTERN_MODE: pattern_mode    <= cfg_wdata[0];
        REG_NOISE_LEVEL:  noise_level     <= cfg_wdata[VAR_W-1:0];
        REG_MOTION_RATIO: motion_ratio_sq <= cfg_wdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic en_up;
  logic haz;
  logic busy;

  // stage a: input register
  logic                    va;
  logic [BIN_W-1:0]        a_bin;
  logic signed [CUR_W-1:0] a_re;
  logic signed [CUR_W-1:0] a_im;
  logic [VAR_W-1:0]        a_noise;
  // stage b: bin fold quotient
  logic                    vb;
  logic [BIN_W-1:0]        b_q;
  logic [BIN_W-1:0]        b_bin;
  logic signed [CUR_W-1:0] b_re;
  logic signed [CUR_W-1:0] b_im;
  logic [VAR_W-1:0]        b_noise;
  logic [36:0]             a_qfull;
  logic [MW-1:0]           b_prod;
  logic [MW-1:0]           b_r1;
  logic [MW-1:0]           b_r2;
  logic [ADDR_W-1:0]       raddr;

  assign en       = ~m_tvalid | m_tready;
  assign en_up    = en & ~(vb & haz);
  assign s_tready = en_up & ~busy;
  assign a_qfull  = 37'(a_bin) * 37'(RECIP);

  always_comb begin
    b_prod = MW'(b_q) * MW'(BINS);
    if (b_prod > MW'(b_bin)) begin
      b_r1 = MW'(b_bin) + MW'(BINS) - b_prod;
    end else begin
      b_r1 = MW'(b_bin) - b_prod;
    end
    b_r2  = (b_r1 >= MW'(BINS)) ? b_r1 - MW'(BINS) : b_r1;
    raddr = b_r2[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en_up) begin
      va <= s_tvalid & s_tready;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      a_bin   <= s_tdata[11:0];
      a_re    <= s_tdata[35:12];
      a_im    <= s_tdata[59:36];
      a_noise <= pattern_mode ? s_tdata[91:60] : noise_level;
      b_q     <= a_qfull[35:24];
      b_bin   <= a_bin;
      b_re    <= a_re;
      b_im    <= a_im;
      b_noise <= a_noise;
    end
  end

  // bins in flight from the read stage up to write-back
  logic              hv [NH];
  logic [ADDR_W-1:0] ha [NH];

  always_comb begin
    haz = 1'b0;
    for (int k = 0; k < NH; k++) begin
      if (hv[k] && ha[k] == raddr) begin
        haz = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NH; k++) begin
        hv[k] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else if (en) begin
      hv[0] <= vb & ~haz;
      for (int k = 1; k < NH; k++) begin
        hv[k] <= hv[k-1];
      end
      m_tvalid <= hv[NH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha[0] <= raddr;
      for (int k = 1; k < NH; k++) begin
        ha[k] <= ha[k-1];
      end
    end
  end

  // state store
  ent_t rd;
  ent_t wr;
  logic mem_we;

  assign mem_we = hv[NH-1] & en;

  skdb_mem #(.BINS(BINS), .ADDR_W(ADDR_W)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (ha[NH-1]),
    .wdata (wr),
    .re    (en),
    .raddr (raddr),
    .rdata (rd),
    .busy  (busy)
  );

  // stage c: state read back
  logic signed [CUR_W-1:0] c_re;
  logic signed [CUR_W-1:0] c_im;
  logic [VAR_W-1:0]        c_noise;

  // stage s1: differences, variance sums, threshold
  logic signed [D_W-1:0]   s1_dre;
  logic signed [D_W-1:0]   s1_dim;
  logic [SUM_W-1:0]        s1_sre;
  logic [SUM_W-1:0]        s1_sim;
  logic [DEN_W-1:0]        s1_dnre;
  logic [DEN_W-1:0]        s1_dnim;
  logic [THR_W-1:0]        s1_thr;
  logic signed [CUR_W-1:0] s1_cre;
  logic signed [CUR_W-1:0] s1_cim;
  logic signed [CUR_W-1:0] s1_pre;
  logic signed [CUR_W-1:0] s1_pim;
  logic [VAR_W-1:0]        s1_noise;

  // stage s2: squares and division numerators
  logic [SQ_W-1:0]         s2_sqre;
  logic [SQ_W-1:0]         s2_sqim;
  logic [NUM_W-1:0]        s2_numre;
  logic [NUM_W-1:0]        s2_numim;
  logic [DEN_W-1:0]        s2_dnre;
  logic [DEN_W-1:0]        s2_dnim;
  logic [THR_W-1:0]        s2_thr;
  logic [SUM_W-1:0]        s2_sre;
  logic [SUM_W-1:0]        s2_sim;
  logic signed [D_W-1:0]   s2_dre;
  logic signed [D_W-1:0]   s2_dim;
  logic signed [CUR_W-1:0] s2_cre;
  logic signed [CUR_W-1:0] s2_cim;
  logic signed [CUR_W-1:0] s2_pre;
  logic signed [CUR_W-1:0] s2_pim;
  logic [VAR_W-1:0]        s2_noise;

  logic signed [2*D_W-1:0] sq_re_full;
  logic signed [2*D_W-1:0] sq_im_full;

  assign sq_re_full = s1_dre * s1_dre;
  assign sq_im_full = s1_dim * s1_dim;

  always_ff @(posedge clk) begin
    if (en) begin
      c_re    <= b_re;
      c_im    <= b_im;
      c_noise <= b_noise;

      s1_dre   <= {c_re[CUR_W-1], c_re} - {rd.prev_re[CUR_W-1], rd.prev_re};
      s1_dim   <= {c_im[CUR_W-1], c_im} - {rd.prev_im[CUR_W-1], rd.prev_im};
      s1_sre   <= {1'b0, rd.err_re} + {1'b0, rd.proc_re};
      s1_sim   <= {1'b0, rd.err_im} + {1'b0, rd.proc_im};
      s1_dnre  <= {2'b0, rd.err_re} + {2'b0, rd.proc_re} + {2'b0, c_noise};
      s1_dnim  <= {2'b0, rd.err_im} + {2'b0, rd.proc_im} + {2'b0, c_noise};
      s1_thr   <= THR_W'(c_noise) * THR_W'(motion_ratio_sq);
      s1_cre   <= c_re;
      s1_cim   <= c_im;
      s1_pre   <= rd.prev_re;
      s1_pim   <= rd.prev_im;
      s1_noise <= c_noise;

      s2_sqre  <= sq_re_full[SQ_W-1:0];
      s2_sqim  <= sq_im_full[SQ_W-1:0];
      // round half up: add half the divisor before dividing
      s2_numre <= NUM_W'({s1_sre, 16'h0000}) + NUM_W'(s1_dnre[DEN_W-1:1]);
      s2_numim <= NUM_W'({s1_sim, 16'h0000}) + NUM_W'(s1_dnim[DEN_W-1:1]);
      s2_dnre  <= s1_dnre;
      s2_dnim  <= s1_dnim;
      s2_thr   <= s1_thr;
      s2_sre   <= s1_sre;
      s2_sim   <= s1_sim;
      s2_dre   <= s1_dre;
      s2_dim   <= s1_dim;
      s2_cre   <= s1_cre;
      s2_cim   <= s1_cim;
      s2_pre   <= s1_pre;
      s2_pim   <= s1_pim;
      s2_noise <= s1_noise;
    end
  end

  side_t dv_in;
  side_t dv_out;
  logic [Q_W-1:0] dq_re;
  logic [Q_W-1:0] dq_im;

  always_comb begin
    dv_in.cur_re  = s2_cre;
    dv_in.cur_im  = s2_cim;
    dv_in.prev_re = s2_pre;
    dv_in.prev_im = s2_pim;
    dv_in.sum_re  = s2_sre;
    dv_in.sum_im  = s2_sim;
    dv_in.noise   = s2_noise;
    dv_in.d_re    = s2_dre;
    dv_in.d_im    = s2_dim;
    // either component over the threshold resets the whole bin
    dv_in.motion  = (s2_sqre > SQ_W'(s2_thr)) || (s2_sqim > SQ_W'(s2_thr));
  end

  skdb_div u_div (
    .clk      (clk),
    .en       (en),
    .num_re   (s2_numre),
    .num_im   (s2_numim),
    .den_re   (s2_dnre),
    .den_im   (s2_dnim),
    .side_in  (dv_in),
    .q_re     (dq_re),
    .q_im     (dq_im),
    .side_out (dv_out)
  );

  // stage p1: gain products
  logic [G_W-1:0]          g_re;
  logic [G_W-1:0]          g_im;
  logic [2*G_W-1:0]        p1_ggre;
  logic [2*G_W-1:0]        p1_ggim;
  logic [NUM_W-1:0]        p1_esre;
  logic [NUM_W-1:0]        p1_esim;
  logic signed [41:0]      p1_gdre;
  logic signed [41:0]      p1_gdim;
  side_t                   p1_sd;
  logic signed [Q_W-1:0]   gs_re;
  logic signed [Q_W-1:0]   gs_im;

  assign g_re  = gain_of(dq_re, dv_out.sum_re, dv_out.noise);
  assign g_im  = gain_of(dq_im, dv_out.sum_im, dv_out.noise);
  assign gs_re = {1'b0, g_re};
  assign gs_im = {1'b0, g_im};

  // stage p2: variance products and filtered values
  logic [63:0]             p2_ggnre;
  logic [63:0]             p2_ggnim;
  logic [VAR_W-1:0]        p2_errre;
  logic [VAR_W-1:0]        p2_errim;
  logic signed [CUR_W-1:0] p2_ore;
  logic signed [CUR_W-1:0] p2_oim;
  side_t                   p2_sd;

  logic [NUM_W:0]          er_re_t;
  logic [NUM_W:0]          er_im_t;
  logic signed [41:0]      st_re_t;
  logic signed [41:0]      st_im_t;
  logic signed [26:0]      o_re_t;
  logic signed [26:0]      o_im_t;

  always_comb begin
    er_re_t = (NUM_W + 1)'(p1_esre) + (NUM_W + 1)'(32'h8000);
    er_im_t = (NUM_W + 1)'(p1_esim) + (NUM_W + 1)'(32'h8000);
    st_re_t = p1_gdre + 42'sd32768;
    st_im_t = p1_gdim + 42'sd32768;
    // arithmetic shift by 16 gives the floor
    o_re_t  = {{3{p1_sd.prev_re[CUR_W-1]}}, p1_sd.prev_re}
            + {st_re_t[41], st_re_t[41:16]};
    o_im_t  = {{3{p1_sd.prev_im[CUR_W-1]}}, p1_sd.prev_im}
            + {st_im_t[41], st_im_t[41:16]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ggre <= (2*G_W)'(g_re) * (2*G_W)'(g_re);
      p1_ggim <= (2*G_W)'(g_im) * (2*G_W)'(g_im);
      p1_esre <= NUM_W'(Q_W'(17'd65536 - Q_W'(g_re))) * NUM_W'(dv_out.sum_re);
      p1_esim <= NUM_W'(Q_W'(17'd65536 - Q_W'(g_im))) * NUM_W'(dv_out.sum_im);
      p1_gdre <= gs_re * dv_out.d_re;
      p1_gdim <= gs_im * dv_out.d_im;
      p1_sd   <= dv_out;

      p2_ggnre <= 64'(p1_ggre) * 64'(p1_sd.noise);
      p2_ggnim <= 64'(p1_ggim) * 64'(p1_sd.noise);
      p2_errre <= sat32(er_re_t[NUM_W:16]);
      p2_errim <= sat32(er_im_t[NUM_W:16]);
      p2_ore   <= sat24(o_re_t);
      p2_oim   <= sat24(o_im_t);
      p2_sd    <= p1_sd;
    end
  end

  // write-back and result
  logic [64:0] pr_re_t;
  logic [64:0] pr_im_t;

  always_comb begin
    pr_re_t = 65'(p2_ggnre) + 65'h80000000;
    pr_im_t = 65'(p2_ggnim) + 65'h80000000;
    if (p2_sd.motion) begin
      wr.prev_re = p2_sd.cur_re;
      wr.prev_im = p2_sd.cur_im;
      wr.err_re  = p2_sd.noise;
      wr.err_im  = p2_sd.noise;
      wr.proc_re = p2_sd.noise;
      wr.proc_im = p2_sd.noise;
    end else begin
      wr.prev_re = p2_ore;
      wr.prev_im = p2_oim;
      wr.err_re  = p2_errre;
      wr.err_im  = p2_errim;
      wr.proc_re = sat32({2'b00, pr_re_t[64:32]});
      wr.proc_im = sat32({2'b00, pr_im_t[64:32]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {wr.prev_im, wr.prev_re};
      m_tuser <= p2_sd.motion;
    end
  end

endmodule

[design/skdb_mem.sv]
// per-bin state memory with a clearing sweep after reset
module skdb_mem #(
  parameter int BINS   = skdb_pkg::BINS_DEF,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  skdb_pkg::ent_t    wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output skdb_pkg::ent_t    rdata,
  output logic              busy
);
  import skdb_pkg::*;

  ent_t              mem [BINS];
  logic [ADDR_W:0]   clr_cnt;

  assign busy = (clr_cnt != (ADDR_W + 1)'(BINS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[ADDR_W-1:0]] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/skdb_div.sv]
// pipelined restoring divider for the two kalman gains, one quotient bit per stage
module skdb_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [skdb_pkg::NUM_W-1:0] num_re,
  input  logic [skdb_pkg::NUM_W-1:0] num_im,
  input  logic [skdb_pkg::DEN_W-1:0] den_re,
  input  logic [skdb_pkg::DEN_W-1:0] den_im,
  input  skdb_pkg::side_t            side_in,
  output logic [skdb_pkg::Q_W-1:0]   q_re,
  output logic [skdb_pkg::Q_W-1:0]   q_im,
  output skdb_pkg::side_t            side_out
);
  import skdb_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
  } dstep_t;

  function automatic dstep_t dstep(input dstep_t s);
    logic [DEN_W:0] r2;
    logic [DEN_W:0] dd;
    dstep_t         n;
    r2 = {s.rem, s.low[Q_W-1]};
    dd = {1'b0, s.den};
    n  = s;
    if (r2 >= dd) begin
      n.rem = DEN_W'(r2 - dd);
      n.q   = {s.q[Q_W-2:0], 1'b1};
    end else begin
      n.rem = r2[DEN_W-1:0];
      n.q   = {s.q[Q_W-2:0], 1'b0};
    end
    n.low = {s.low[Q_W-2:0], 1'b0};
    return n;
  endfunction

  dstep_t in_re;
  dstep_t in_im;
  dstep_t st_re [DIV_STAGES];
  dstep_t st_im [DIV_STAGES];
  side_t  st_sd [DIV_STAGES];

  // upper numerator bits are known to stay below the divisor
  always_comb begin
    in_re.rem = DEN_W'(num_re[NUM_W-1:Q_W]);
    in_re.den = den_re;
    in_re.low = num_re[Q_W-1:0];
    in_re.q   = '0;
    in_im.rem = DEN_W'(num_im[NUM_W-1:Q_W]);
    in_im.den = den_im;
    in_im.low = num_im[Q_W-1:0];
    in_im.q   = '0;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          st_re[k] <= dstep(in_re);
          st_im[k] <= dstep(in_im);
          st_sd[k] <= side_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          st_re[k] <= dstep(st_re[k-1]);
          st_im[k] <= dstep(st_im[k-1]);
          st_sd[k] <= st_sd[k-1];
        end
      end
    end
  end

  assign q_re     = st_re[DIV_STAGES-1].q;
  assign q_im     = st_im[DIV_STAGES-1].q;
  assign side_out = st_sd[DIV_STAGES-1];

endmodule
